FILE: hdl/i2d_pkg.sv
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared widths, character codes and handoff types for the 64-bit integer to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2d_pkg;

	localparam int VALUE_W    = 64;
	localparam int CHAR_W     = 7;
	localparam int NUM_DIGITS = 20;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

	// Converted number handed from the converter to the character emitter
	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} dab_res_t;

endpackage

FILE: hdl/i2d_stream_if.sv
// ----------------------------------------------------------------------------
// i2d_stream_if
// Valid/ready channels: number in, ASCII characters out.
// ----------------------------------------------------------------------------
interface i2d_in_if;
	logic                        valid;
	logic                        ready;
	logic [i2d_pkg::VALUE_W-1:0] value;
	logic                        mode;

	modport source (output valid, output value, output mode, input ready);
	modport sink   (input valid, input value, input mode, output ready);
endinterface

interface i2d_out_if;
	logic                       valid;
	logic                       ready;
	logic [i2d_pkg::CHAR_W-1:0] char_code;
	logic                       last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

FILE: hdl/int64_to_decimal_ascii_core.sv
// Sequence: after acceptance the converter shifts in all 64 magnitude bits and hands the
//   result to the emitter, which skips leading zeros and then enters emission; the last
//   character is registered after the minus sign, if any, and the other digits.
// Overlap: the emitter works on one number while the converter takes the next one, so
//   the bit-serial converter sets the rate when the sink keeps up.
// Reset: arst_n asynchronous, active low; clears all control, no pending output.
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_core
// Converts a 64-bit unsigned or two's complement number into its decimal
// ASCII text, most significant character first, last character flagged.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii_core (
	input  logic     clk,
	input  logic     arst_n,
	i2d_in_if.sink   din,
	i2d_out_if.source dout
);

	logic                        neg;
	logic [i2d_pkg::VALUE_W-1:0] mag;
	logic                        start;
	logic                        dab_idle;
	logic                        take;
	i2d_pkg::dab_res_t           res;

	// Sign and magnitude of the incoming transaction
	assign neg   = din.mode && din.value[i2d_pkg::VALUE_W-1];
	assign mag   = neg ? (~din.value + i2d_pkg::VALUE_W'(1)) : din.value;
	assign start = din.valid && din.ready;

	assign din.ready = dab_idle;

	i2d_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mag    (mag),
		.neg    (neg),
		.idle   (dab_idle),
		.res    (res),
		.take   (take)
	);

	i2d_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.take   (take),
		.dout   (dout)
	);

endmodule

FILE: hdl/i2d_dabble.sv
// ----------------------------------------------------------------------------
// i2d_dabble
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit
// per cycle, MSB first. Holds the result until the emitter takes it.
// ----------------------------------------------------------------------------
module i2d_dabble (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [i2d_pkg::VALUE_W-1:0] mag,
	input  logic                        neg,
	output logic                        idle,
	output i2d_pkg::dab_res_t           res,
	input  logic                        take
);

	logic                          busy_q;
	logic                          full_q;
	logic                          neg_q;
	logic [i2d_pkg::BIT_CNT_W-1:0] cnt_q;
	logic [i2d_pkg::VALUE_W-1:0]   bin_q;
	logic [i2d_pkg::BCD_W-1:0]     bcd_q;
	logic [i2d_pkg::BCD_W-1:0]     adj;

	// Add 3 to every digit of 5 or more ahead of the shift
	always_comb begin
		for (int d = 0; d < i2d_pkg::NUM_DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	// Control: busy while shifting, full while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			full_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == i2d_pkg::BIT_CNT_W'(i2d_pkg::VALUE_W - 1)) begin
					busy_q <= 1'b0;
					full_q <= 1'b1;
				end
			end else if (full_q && take) begin
				full_q <= 1'b0;
			end
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			bin_q <= {bin_q[i2d_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[i2d_pkg::BCD_W-2:0], bin_q[i2d_pkg::VALUE_W-1]};
		end
	end

	assign idle      = !busy_q && !full_q;
	assign res.valid = full_q;
	assign res.neg   = neg_q;
	assign res.bcd   = bcd_q;

endmodule

FILE: hdl/i2d_emit.sv
// ----------------------------------------------------------------------------
// i2d_emit
// Character emitter: optional minus sign, leading zero skip one digit per
// cycle, then one ASCII digit per transaction through an output register.
// ----------------------------------------------------------------------------
module i2d_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  i2d_pkg::dab_res_t res,
	output logic              take,
	i2d_out_if.source         dout
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SIGN = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                    state_q;
	logic [i2d_pkg::DIG_CNT_W-1:0] dcnt_q;
	logic [i2d_pkg::BCD_W-1:0]     bcd_q;
	logic                          oval_q;
	logic [i2d_pkg::CHAR_W-1:0]    char_q;
	logic                          last_q;
	logic                          slot_free;
	logic                          load_out;
	logic [3:0]                    top_dig;

	assign top_dig   = bcd_q[i2d_pkg::BCD_W-1 -: 4];
	assign slot_free = !oval_q || dout.ready;
	assign load_out  = slot_free && (state_q == ST_SIGN || state_q == ST_EMIT);
	assign take      = res.valid && (state_q == ST_IDLE);

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dcnt_q  <= '0;
			oval_q  <= 1'b0;
		end else begin
			if (load_out) begin
				oval_q <= 1'b1;
			end else if (dout.ready) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						dcnt_q  <= i2d_pkg::DIG_CNT_W'(i2d_pkg::NUM_DIGITS);
						state_q <= res.neg ? ST_SIGN : ST_SKIP;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_dig == 4'd0 && dcnt_q > i2d_pkg::DIG_CNT_W'(1)) begin
						dcnt_q <= dcnt_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						dcnt_q <= dcnt_q - 1'b1;
						if (dcnt_q == i2d_pkg::DIG_CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit shift register and output payload
	always_ff @(posedge clk) begin
		if (take) begin
			bcd_q <= res.bcd;
		end else if (state_q == ST_SKIP) begin
			if (top_dig == 4'd0 && dcnt_q > i2d_pkg::DIG_CNT_W'(1)) begin
				bcd_q <= {bcd_q[i2d_pkg::BCD_W-5:0], 4'd0};
			end
		end else if (state_q == ST_EMIT && slot_free) begin
			bcd_q <= {bcd_q[i2d_pkg::BCD_W-5:0], 4'd0};
		end

		if (state_q == ST_SIGN && slot_free) begin
			char_q <= i2d_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			char_q <= i2d_pkg::CHAR_ZERO + i2d_pkg::CHAR_W'(top_dig);
			last_q <= (dcnt_q == i2d_pkg::DIG_CNT_W'(1));
		end
	end

	assign dout.valid     = oval_q;
	assign dout.char_code = char_q;
	assign dout.last      = last_q;

endmodule
